// ===== rtl/gdda_pkg.sv =====
// Shared types and constants of the grid ray caster (DDA).
// Used by gdda_dp, gdda_ctrl, grid_ray_caster_dda and the testbench; no dependencies.
package gdda_pkg;

   localparam int POS_W      = 16;
   localparam int VEC_W      = 16;
   localparam int SW_W       = 12;
   localparam int COL_W      = 11;
   localparam int CELL_W     = 6;
   localparam int DIST_W     = 18;
   localparam int SIDE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;
   localparam int WDIV_W     = 13;  // clamped screen width
   localparam int RAY_W      = 18;  // signed ray component, Q.14
   localparam int ABS_W      = 17;  // magnitude of a ray component
   localparam int FRAC_W     = 10;
   localparam int ONE_Q10    = 1024;
   localparam int ONE_Q14    = 16384;
   localparam int DIST_MAX   = 262143;
   localparam int CAM_MAX    = 32767;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_X   = 3'd0,
      CSR_POS_Y   = 3'd1,
      CSR_DIR_X   = 3'd2,
      CSR_DIR_Y   = 3'd3,
      CSR_PLANE_X = 3'd4,
      CSR_PLANE_Y = 3'd5,
      CSR_WIDTH   = 3'd6
   } csr_reg_type;

   localparam logic [SIDE_W-1:0] SIDE_X_POS = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_Y_POS = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_X_NEG = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_Y_NEG = 2'd3;

   typedef struct packed {
      logic clr_step;
      logic map_wr;
      logic item_ld;
      logic cam_go;
      logic cam_ld;
      logic mul;
      logic add;
      logic setup;
      logic step;
      logic set_esc;
      logic dist_go;
      logic out_ld;
   } gdda_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic start_esc;
      logic esc;
      logic wall;
      logic lim;
   } gdda_sts_type;

endpackage

// ===== rtl/gdda_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by camera and distance.
// Depends on nothing.
module gdda_div #(
   parameter int DW = 32,
   parameter int VW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNTW = $clog2(DW + 1);

   logic [CNTW-1:0] cnt_ff;
   logic [VW-1:0]   rem_ff;
   logic [VW-1:0]   dvs_ff;
   logic [DW-1:0]   quo_ff;
   logic [VW:0]     trial;
   logic [VW:0]     diff;
   logic            ge;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNTW'(DW);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= ge ? diff[VW-1:0] : trial[VW-1:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign done     = cnt_ff == '0;
   assign quotient = quo_ff;

endmodule

// ===== rtl/gdda_dp.sv =====
// Datapath: config registers, wall map memory, camera/ray math, DDA stepper, output register.
// Depends on gdda_pkg and gdda_div.
module gdda_dp #(
   parameter int MAP_DIM     = 64,
   parameter int MAX_COLUMNS = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [gdda_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gdda_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [gdda_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  gdda_pkg::gdda_cmd_type              cmd,
   output gdda_pkg::gdda_sts_type              sts,
   output logic [gdda_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int DEPTH = MAP_DIM * MAP_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAP_DIM);
   localparam int SPAN  = (MAP_DIM > 64) ? MAP_DIM : 64;
   localparam int MW    = $clog2(SPAN + 1) + 1;
   localparam int NW    = MW + 11;
   localparam int DW    = NW - 1 + 14;
   localparam int SL    = 4 * MAP_DIM + 4;
   localparam int CW    = $clog2(SL + 1);
   localparam int TW    = $clog2(1024 * (SL + 2));
   localparam int PW    = TW + gdda_pkg::ABS_W;

   // config registers
   logic        [gdda_pkg::POS_W-1:0] pos_x_ff, pos_y_ff;
   logic signed [gdda_pkg::VEC_W-1:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic        [gdda_pkg::SW_W-1:0]  width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         dir_x_ff   <= 16'hC000;
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= 16'd10813;
         width_ff   <= 12'd640;
      end else if (csr_valid) begin
         case (csr_index)
            gdda_pkg::CSR_POS_X:   pos_x_ff   <= csr_wdata;
            gdda_pkg::CSR_POS_Y:   pos_y_ff   <= csr_wdata;
            gdda_pkg::CSR_DIR_X:   dir_x_ff   <= csr_wdata;
            gdda_pkg::CSR_DIR_Y:   dir_y_ff   <= csr_wdata;
            gdda_pkg::CSR_PLANE_X: plane_x_ff <= csr_wdata;
            gdda_pkg::CSR_PLANE_Y: plane_y_ff <= csr_wdata;
            gdda_pkg::CSR_WIDTH:   width_ff   <= csr_wdata[gdda_pkg::SW_W-1:0];
            default: ;
         endcase
      end
   end

   // input beat fields
   logic [gdda_pkg::COL_W-1:0]  in_col;
   logic [gdda_pkg::CELL_W-1:0] in_cx, in_cy;
   logic                        in_wall;
   assign in_col  = req_tdata[10:0];
   assign in_cx   = req_tdata[16:11];
   assign in_cy   = req_tdata[22:17];
   assign in_wall = req_tdata[23];

   // working registers
   logic        [gdda_pkg::COL_W-1:0] col_ff;
   logic signed [gdda_pkg::VEC_W-1:0] cam_ff;
   logic signed [31:0]                prod_x_ff, prod_y_ff;
   logic signed [gdda_pkg::RAY_W-1:0] rx_ff, ry_ff;
   logic signed [MW-1:0]              mx_ff, my_ff;
   logic        [PW-1:0]              p_ff, q_ff;
   logic        [CW-1:0]              step_ff;
   logic                              side_ff;
   logic                              esc_ff;
   logic        [AW-1:0]              clr_ff;

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end
   assign sts.clr_last = clr_ff == AW'(DEPTH - 1);

   // ray magnitudes and signs
   logic                      rx_neg, ry_neg;
   logic [gdda_pkg::ABS_W-1:0] ax, ay;
   assign rx_neg = rx_ff[gdda_pkg::RAY_W-1];
   assign ry_neg = ry_ff[gdda_pkg::RAY_W-1];
   assign ax = rx_neg ? gdda_pkg::ABS_W'(-rx_ff) : gdda_pkg::ABS_W'(rx_ff);
   assign ay = ry_neg ? gdda_pkg::ABS_W'(-ry_ff) : gdda_pkg::ABS_W'(ry_ff);

   // divider operands
   logic [gdda_pkg::WDIV_W-1:0] w_cl;
   logic signed [NW-1:0]        num_x, num_y, num_sel;
   logic [NW-2:0]               num_abs;
   logic [DW-1:0]               div_dvd, quo;
   logic [gdda_pkg::ABS_W-1:0]  div_dvs;

   always_comb begin
      if (width_ff == '0) begin
         w_cl = gdda_pkg::WDIV_W'(1);
      end else if (32'(width_ff) > MAX_COLUMNS) begin
         w_cl = gdda_pkg::WDIV_W'(MAX_COLUMNS);
      end else begin
         w_cl = {1'b0, width_ff};
      end
   end

   assign num_x = ($signed(NW'(mx_ff)) <<< 10) - $signed(NW'(pos_x_ff))
                  + (rx_neg ? NW'(gdda_pkg::ONE_Q10) : NW'(0));
   assign num_y = ($signed(NW'(my_ff)) <<< 10) - $signed(NW'(pos_y_ff))
                  + (ry_neg ? NW'(gdda_pkg::ONE_Q10) : NW'(0));
   assign num_sel = side_ff ? num_y : num_x;
   assign num_abs = num_sel[NW-1] ? (NW-1)'(-num_sel) : (NW-1)'(num_sel);

   assign div_dvd = cmd.cam_go ? DW'({col_ff, 15'b0}) : {num_abs, 14'b0};
   assign div_dvs = cmd.cam_go ? gdda_pkg::ABS_W'(w_cl) : (side_ff ? ay : ax);

   gdda_div #(
      .DW (DW),
      .VW (gdda_pkg::ABS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.cam_go | cmd.dist_go),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (sts.div_done),
      .quotient (quo)
   );

   // setup values
   logic [10:0] tx0, ty0;
   logic [27:0] p0, q0;
   assign tx0 = rx_neg ? {1'b0, pos_x_ff[9:0]} : 11'd1024 - {1'b0, pos_x_ff[9:0]};
   assign ty0 = ry_neg ? {1'b0, pos_y_ff[9:0]} : 11'd1024 - {1'b0, pos_y_ff[9:0]};
   assign p0  = 28'(tx0) * 28'(ay);
   assign q0  = 28'(ty0) * 28'(ax);
   assign sts.start_esc = (32'(pos_x_ff[15:10]) >= MAP_DIM) ||
                          (32'(pos_y_ff[15:10]) >= MAP_DIM);

   // one DDA step; equal distances take the y step
   logic                 take_x, oob;
   logic signed [MW-1:0] mx_n, my_n;
   logic [AW-1:0]        rd_addr;

   always_comb begin
      take_x = (ax != '0) && ((ay == '0) || (p_ff < q_ff));
      mx_n   = mx_ff;
      my_n   = my_ff;
      if (take_x) begin
         mx_n = rx_neg ? mx_ff - MW'(1) : mx_ff + MW'(1);
      end else begin
         my_n = ry_neg ? my_ff - MW'(1) : my_ff + MW'(1);
      end
      oob = (mx_n < 0) || (my_n < 0) || (mx_n >= MW'(MAP_DIM)) || (my_n >= MW'(MAP_DIM));
      rd_addr = oob ? '0 : AW'(32'(my_n[IW-1:0]) * MAP_DIM + 32'(mx_n[IW-1:0]));
   end

   always_ff @(posedge clock) begin
      if (cmd.item_ld) begin
         col_ff <= in_col;
      end
      if (cmd.cam_ld) begin
         if (quo > DW'(gdda_pkg::CAM_MAX + gdda_pkg::ONE_Q14)) begin
            cam_ff <= 16'sd32767;
         end else begin
            cam_ff <= $signed(quo[15:0] - 16'd16384);
         end
      end
      if (cmd.mul) begin
         prod_x_ff <= plane_x_ff * cam_ff;
         prod_y_ff <= plane_y_ff * cam_ff;
      end
      if (cmd.add) begin
         rx_ff <= $signed(gdda_pkg::RAY_W'(dir_x_ff)) + $signed(prod_x_ff[31:14]);
         ry_ff <= $signed(gdda_pkg::RAY_W'(dir_y_ff)) + $signed(prod_y_ff[31:14]);
      end
      if (cmd.setup) begin
         p_ff    <= PW'(p0);
         q_ff    <= PW'(q0);
         mx_ff   <= MW'(pos_x_ff[15:10]);
         my_ff   <= MW'(pos_y_ff[15:10]);
         step_ff <= '0;
         side_ff <= 1'b0;
         esc_ff  <= sts.start_esc;
      end else if (cmd.step) begin
         if (take_x) begin
            p_ff <= p_ff + (PW'(ay) << 10);
         end else begin
            q_ff <= q_ff + (PW'(ax) << 10);
         end
         mx_ff   <= mx_n;
         my_ff   <= my_n;
         side_ff <= !take_x;
         esc_ff  <= oob;
         step_ff <= step_ff + CW'(1);
      end else if (cmd.set_esc) begin
         esc_ff <= 1'b1;
      end
   end

   assign sts.esc  = esc_ff;
   assign sts.lim  = step_ff == CW'(SL);

   // wall map
   logic          map_ff [DEPTH];
   logic          rd_ff;
   logic          wr_en, wr_d;
   logic [AW-1:0] wr_a;

   assign wr_en = cmd.clr_step ||
                  (cmd.map_wr && (32'(in_cx) < MAP_DIM) && (32'(in_cy) < MAP_DIM));
   assign wr_a  = cmd.clr_step ? clr_ff : AW'(32'(in_cy) * MAP_DIM + 32'(in_cx));
   assign wr_d  = cmd.clr_step ? 1'b0 : in_wall;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_a] <= wr_d;
      end
      rd_ff <= map_ff[rd_addr];
   end
   assign sts.wall = rd_ff;

   // result register
   logic                         ray_zero;
   logic [gdda_pkg::DIST_W-1:0]  dist_out_ff;
   logic [gdda_pkg::SIDE_W-1:0]  side_out_ff;
   logic [gdda_pkg::CELL_W-1:0]  hx_out_ff, hy_out_ff;
   logic [gdda_pkg::COL_W-1:0]   col_out_ff;
   logic                         esc_out_ff;

   assign ray_zero = side_ff ? (ay == '0) : (ax == '0);

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         col_out_ff <= col_ff;
         esc_out_ff <= esc_ff;
         if (esc_ff) begin
            dist_out_ff <= gdda_pkg::DIST_W'(gdda_pkg::DIST_MAX);
            side_out_ff <= gdda_pkg::SIDE_X_POS;
            hx_out_ff   <= '0;
            hy_out_ff   <= '0;
         end else begin
            if (ray_zero || (quo > DW'(gdda_pkg::DIST_MAX))) begin
               dist_out_ff <= gdda_pkg::DIST_W'(gdda_pkg::DIST_MAX);
            end else begin
               dist_out_ff <= quo[gdda_pkg::DIST_W-1:0];
            end
            if (side_ff) begin
               side_out_ff <= ry_neg ? gdda_pkg::SIDE_Y_NEG : gdda_pkg::SIDE_Y_POS;
            end else begin
               side_out_ff <= rx_neg ? gdda_pkg::SIDE_X_NEG : gdda_pkg::SIDE_X_POS;
            end
            hx_out_ff <= mx_ff[gdda_pkg::CELL_W-1:0];
            hy_out_ff <= my_ff[gdda_pkg::CELL_W-1:0];
         end
      end
   end

   assign rsp_tdata = {5'b0, hy_out_ff, hx_out_ff, side_out_ff, dist_out_ff, col_out_ff};
   assign rsp_tuser = esc_out_ff;

endmodule

// ===== rtl/gdda_ctrl.sv =====
// Controller: sequences clear sweep, map writes, ray setup, DDA steps and result handoff.
// Depends on gdda_pkg.
module gdda_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tuser,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output gdda_pkg::gdda_cmd_type cmd,
   input  gdda_pkg::gdda_sts_type sts
);

   typedef enum logic [11:0] {
      ST_CLEAR     = 12'b0000_0000_0001,
      ST_IDLE      = 12'b0000_0000_0010,
      ST_CAM_GO    = 12'b0000_0000_0100,
      ST_CAM_WAIT  = 12'b0000_0000_1000,
      ST_MUL       = 12'b0000_0001_0000,
      ST_ADD       = 12'b0000_0010_0000,
      ST_SETUP     = 12'b0000_0100_0000,
      ST_STEP      = 12'b0000_1000_0000,
      ST_CHECK     = 12'b0001_0000_0000,
      ST_DIST_GO   = 12'b0010_0000_0000,
      ST_DIST_WAIT = 12'b0100_0000_0000,
      ST_FINISH    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser) begin
                  cmd.item_ld = 1'b1;
                  state_in    = ST_CAM_GO;
               end else begin
                  cmd.map_wr = 1'b1;
               end
            end
         end
         ST_CAM_GO: begin
            cmd.cam_go = 1'b1;
            state_in   = ST_CAM_WAIT;
         end
         ST_CAM_WAIT: begin
            if (sts.div_done) begin
               cmd.cam_ld = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.start_esc ? ST_FINISH : ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (sts.esc) begin
               state_in = ST_FINISH;
            end else if (sts.wall) begin
               state_in = ST_DIST_GO;
            end else if (sts.lim) begin
               cmd.set_esc = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_DIST_GO: begin
            cmd.dist_go = 1'b1;
            state_in    = ST_DIST_WAIT;
         end
         ST_DIST_WAIT: begin
            if (sts.div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending beat");
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_FINISH))
      else $error("result valid raised outside finish");
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.cam_go || cmd.dist_go) |-> sts.div_done)
      else $error("divider started while busy");
   a_map_wr_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.map_wr |-> (req_tvalid && !req_tuser && state_ff == ST_IDLE))
      else $error("map write without accepted beat");
`endif

endmodule

// ===== rtl/grid_ray_caster_dda.sv =====
// Top level of the grid ray caster (DDA): ports, controller and datapath.
// Depends on gdda_pkg, gdda_ctrl, gdda_dp (and gdda_div below it).
//
// channel | ports             | beat
// --------+-------------------+------------------------------------------------
// req     | req_t*            | map cell write (tuser 0) or ray cast (tuser 1)
// rsp     | rsp_t*            | one per ray: column, distance, side, hit cell
// csr     | csr_valid/ready   | register index and write data, always ready
//
// Map write: one beat per cycle while idle. A ray beat holds req not ready until its
// result is loaded; the serial divider (camera x, then distance, DW = 32 at MAP_DIM 64)
// and the DDA step/map-read loop run in between.
// After reset the map is swept clear while req is held not ready.
// A finished result waits in the output register while the next beat is taken.
module grid_ray_caster_dda #(
   parameter int MAP_DIM     = 64,
   parameter int MAX_COLUMNS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // column[10:0], cell_x[16:11], cell_y[22:17], wall[23]
   input  logic [23:0] req_tdata,
   // func[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_column[10:0], distance[28:11], side[30:29], hit_x[36:31], hit_y[42:37]
   output logic [47:0] rsp_tdata,
   // escaped[0]
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   gdda_pkg::gdda_cmd_type cmd;
   gdda_pkg::gdda_sts_type sts;

   assign csr_ready = 1'b1;

   gdda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   gdda_dp #(
      .MAP_DIM     (MAP_DIM),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for grid_ray_caster_dda: map writes and ray casts, each
// ray checked against an in-bench DDA walk. Depends on gdda_pkg and the RTL.
module testbench;

   localparam int GRID      = 64;
   localparam int SETTLE    = 800;     // cycles for a ray still in flight
   localparam int WDOG_MAX  = 60000;   // covers the clear sweep after reset
   localparam int PHASES    = 8;
   localparam int RAND_ITEMS = 75;

   typedef struct {
      logic        func;
      logic [10:0] column;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        wall;
   } req_item_type;

   typedef struct {
      logic [10:0] column;
      logic [17:0] distance;
      logic [1:0]  side;
      logic [5:0]  hit_x;
      logic [5:0]  hit_y;
      logic        escaped;
   } hit_report_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [23:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tuser;
   logic [47:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   grid_ray_caster_dda dut (.*);

   // bench copy of block state
   bit                 wall_map [GRID*GRID];
   logic [15:0]        pos_x_q, pos_y_q;
   logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
   logic [11:0]        width_q;

   req_item_type   pending_items [$];
   hit_report_type expected_hits [$];
   int             send_idle_pct, recv_stall_pct;
   int             mismatches, quiet_cycles;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic hit_report_type trace_ray(logic [10:0] col);
      longint w, cam, rx, ry, ax, ay, tx, ty, num, ray;
      int mx, my, sx, sy, side, steps;
      bit hit, esc;
      hit_report_type r;
      w = width_q;
      if (w == 0) w = 1;
      if (w > 2048) w = 2048;
      cam = (2 * longint'(col) * gdda_pkg::ONE_Q14) / w - gdda_pkg::ONE_Q14;
      if (cam > 32767) cam = 32767;
      if (cam < -32768) cam = -32768;
      rx = longint'(dir_x_q) + ((longint'(plane_x_q) * cam) >>> 14);
      ry = longint'(dir_y_q) + ((longint'(plane_y_q) * cam) >>> 14);
      ax = rx < 0 ? -rx : rx;
      ay = ry < 0 ? -ry : ry;
      mx = pos_x_q >> 10;
      my = pos_y_q >> 10;
      sx = rx < 0 ? -1 : 1;
      sy = ry < 0 ? -1 : 1;
      tx = rx < 0 ? (pos_x_q & 1023) : 1024 - (pos_x_q & 1023);
      ty = ry < 0 ? (pos_y_q & 1023) : 1024 - (pos_y_q & 1023);
      hit = 0;
      side = 0;
      esc = (mx >= GRID || my >= GRID);
      for (steps = 0; !hit && !esc && steps < 4*GRID + 4; steps++) begin
         // ties go to the y step
         if (ax != 0 && (ay == 0 || tx * ay < ty * ax)) begin
            tx += 1024; mx += sx; side = 0;
         end else begin
            ty += 1024; my += sy; side = 1;
         end
         if (mx < 0 || my < 0 || mx >= GRID || my >= GRID) esc = 1;
         else if (wall_map[my*GRID + mx]) hit = 1;
      end
      if (!hit) esc = 1;
      r.column = col;
      r.escaped = esc;
      if (esc) begin
         r.distance = gdda_pkg::DIST_MAX;
         r.side = gdda_pkg::SIDE_X_POS;
         r.hit_x = 0;
         r.hit_y = 0;
      end else begin
         if (side == 0) begin
            num = longint'(mx) * 1024 - pos_x_q + (sx < 0 ? 1024 : 0);
            ray = rx;
            r.side = rx < 0 ? gdda_pkg::SIDE_X_NEG : gdda_pkg::SIDE_X_POS;
         end else begin
            num = longint'(my) * 1024 - pos_y_q + (sy < 0 ? 1024 : 0);
            ray = ry;
            r.side = ry < 0 ? gdda_pkg::SIDE_Y_NEG : gdda_pkg::SIDE_Y_POS;
         end
         if (num < 0) num = -num;
         if (ray < 0) ray = -ray;
         if (ray == 0) num = gdda_pkg::DIST_MAX;
         else num = (num << 14) / ray;
         r.distance = num > gdda_pkg::DIST_MAX ? gdda_pkg::DIST_MAX : num;
         r.hit_x = mx;
         r.hit_y = my;
      end
      return r;
   endfunction

   // driver: next beat goes out once the current one is taken
   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= it.func;
            req_tdata  <= {it.wall, it.cell_y, it.cell_x, it.column};
            if (it.func) expected_hits.push_back(trace_ray(it.column));
            else wall_map[it.cell_y*GRID + it.cell_x] = it.wall;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor, receiver stalls and watchdog
   always @(posedge clock) begin
      hit_report_type want, got;
      if (reset) begin
         rsp_tready   <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.column   = rsp_tdata[10:0];
            got.distance = rsp_tdata[28:11];
            got.side     = rsp_tdata[30:29];
            got.hit_x    = rsp_tdata[36:31];
            got.hit_y    = rsp_tdata[42:37];
            got.escaped  = rsp_tuser;
            if (expected_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat col=%0d", got.column);
            end else begin
               want = expected_hits.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp col=%0d dist=%0d side=%0d hit=%0d,%0d esc=%0d",
                               " | got col=%0d dist=%0d side=%0d hit=%0d,%0d esc=%0d"},
                        want.column, want.distance, want.side, want.hit_x, want.hit_y,
                        want.escaped, got.column, got.distance, got.side, got.hit_x,
                        got.hit_y, got.escaped);
               end
            end
         end
      end
   end

   task automatic write_reg(gdda_pkg::csr_reg_type idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unique case (idx)
         gdda_pkg::CSR_POS_X:   pos_x_q   = val;
         gdda_pkg::CSR_POS_Y:   pos_y_q   = val;
         gdda_pkg::CSR_DIR_X:   dir_x_q   = val;
         gdda_pkg::CSR_DIR_Y:   dir_y_q   = val;
         gdda_pkg::CSR_PLANE_X: plane_x_q = val;
         gdda_pkg::CSR_PLANE_Y: plane_y_q = val;
         gdda_pkg::CSR_WIDTH:   width_q   = val[11:0];
         default: ;
      endcase
   endtask

   task automatic set_view(logic [15:0] px, logic [15:0] py, logic [15:0] dx,
                           logic [15:0] dy, logic [15:0] plx, logic [15:0] ply,
                           logic [15:0] w);
      write_reg(gdda_pkg::CSR_POS_X, px);
      write_reg(gdda_pkg::CSR_POS_Y, py);
      write_reg(gdda_pkg::CSR_DIR_X, dx);
      write_reg(gdda_pkg::CSR_DIR_Y, dy);
      write_reg(gdda_pkg::CSR_PLANE_X, plx);
      write_reg(gdda_pkg::CSR_PLANE_Y, ply);
      write_reg(gdda_pkg::CSR_WIDTH, w);
   endtask

   task automatic queue_item(logic func, logic [10:0] col, logic [5:0] cx,
                             logic [5:0] cy, logic wall);
      req_item_type it;
      it.func = func; it.column = col; it.cell_x = cx; it.cell_y = cy; it.wall = wall;
      pending_items.push_back(it);
   endtask

   task automatic drain;
      while (pending_items.size() > 0 || req_tvalid || expected_hits.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int ph, n;
      logic [10:0] col;
      reset = 1'b1;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      send_idle_pct = 0; recv_stall_pct = 0;
      mismatches = 0;
      foreach (wall_map[i]) wall_map[i] = 0;
      pos_x_q = 0; pos_y_q = 0; dir_x_q = -16384; dir_y_q = 0;
      plane_x_q = 0; plane_y_q = 10813; width_q = 640;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: corner walls, a cleared cell, edge columns under reset view
      queue_item(1'b1, 11'd0, 6'd0, 6'd0, 1'b0);   // empty map: escape
      queue_item(1'b0, 11'h7FF, 6'd0, 6'd0, 1'b1);
      queue_item(1'b0, 11'd0, 6'd63, 6'd63, 1'b1);
      queue_item(1'b0, 11'd0, 6'd63, 6'd0, 1'b1);
      queue_item(1'b0, 11'd0, 6'd0, 6'd63, 1'b1);
      queue_item(1'b0, 11'd0, 6'd0, 6'd1, 1'b1);
      queue_item(1'b0, 11'd0, 6'd1, 6'd0, 1'b1);
      queue_item(1'b1, 11'd0, 6'd0, 6'd0, 1'b0);
      queue_item(1'b1, 11'd639, 6'd0, 6'd0, 1'b0);
      queue_item(1'b1, 11'd320, 6'd0, 6'd0, 1'b0);
      queue_item(1'b1, 11'd2047, 6'h3F, 6'h3F, 1'b1);  // column past width
      queue_item(1'b0, 11'd0, 6'd1, 6'd0, 1'b0);
      queue_item(1'b1, 11'd320, 6'd0, 6'd0, 1'b0);
      drain();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         case (ph)
            0: set_view(16'd33280, 16'd33280, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813, 16'd2048);
            1: set_view(16'd0, 16'd0, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, 16'd0);
            2: set_view(16'hFFFF, 16'hFFFF, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
                        16'hFFFF);
            3: set_view(16'd20000, 16'd40000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1);
            4: set_view(16'd30000, 16'd30000, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd640);
            5: set_view(16'd33792, 16'd33792, 16'sd16384, 16'sd16384, 16'sd8192, -16'sd8192,
                        16'd4095);
            default: set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(0, 4095));
         endcase
         for (n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(99) < 40)
               queue_item(1'b0, $urandom, $urandom, $urandom, $urandom_range(99) < 75);
            else begin
               col = ($urandom_range(1)) ? $urandom : $urandom_range(0, 639);
               queue_item(1'b1, col, $urandom, $urandom, $urandom);
            end
         end
         drain();
      end

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
